FILE: rtl/core/dns_query_responder_parser_macros.svh
// ---------------------------------------------------------------------------
// DNS query parser assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef DNS_QUERY_RESPONDER_PARSER_MACROS_SVH
`define DNS_QUERY_RESPONDER_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define DQRP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DQRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dqrp_pkg.sv
// ---------------------------------------------------------------------------
// DNS query parser package
// Beat types, parse phases, response codes and blocked-name tables.
// ---------------------------------------------------------------------------
`default_nettype none

package dqrp_pkg;

  localparam int MAX_PACKET_DEF = 512;
  localparam int HEADER_BYTES   = 12;
  localparam int ANSWER_BYTES   = 16;
  localparam int NAME_WIRE      = 19;
  localparam int RESP_LEN_MAX   = 1023;
  localparam int LABEL_MAX      = 63;

  localparam logic [7:0] FLAG_QR     = 8'h80;
  localparam logic [7:0] OPCODE_MASK = 8'h78;
  localparam logic [7:0] PTR_MASK    = 8'hc0;

  localparam logic [3:0] RCODE_NOERROR  = 4'd0;
  localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;
  localparam logic [3:0] RCODE_NOTIMP   = 4'd4;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4,
    PH_UNSUP  = 3'd5,
    PH_BAD    = 3'd6
  } dqrp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dqrp_in_t;

  typedef struct packed {
    logic       drop;
    logic [9:0] response_length;
    logic [7:0] flags_high;
    logic [3:0] response_code;
    logic       answer_count;
  } dqrp_out_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  // wire-format blocked names; sel 0 ends in .org, sel 1 in .com
  function automatic logic [7:0] name_char(input logic [4:0] idx, input logic sel);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'd5;
      5'd1:    c = 8'h6c;
      5'd2:    c = 8'h6f;
      5'd3:    c = 8'h63;
      5'd4:    c = 8'h61;
      5'd5:    c = 8'h6c;
      5'd6:    c = 8'd7;
      5'd7:    c = 8'h61;
      5'd8:    c = 8'h64;
      5'd9:    c = 8'h67;
      5'd10:   c = 8'h75;
      5'd11:   c = 8'h61;
      5'd12:   c = 8'h72;
      5'd13:   c = 8'h64;
      5'd14:   c = 8'd3;
      5'd15:   c = sel ? 8'h63 : 8'h6f;
      5'd16:   c = sel ? 8'h6f : 8'h72;
      5'd17:   c = sel ? 8'h6d : 8'h67;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dqrp_parser.sv
// ---------------------------------------------------------------------------
// DNS query parser core
// Per-beat header/question state update and end-of-packet verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module dqrp_parser
  import dqrp_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire dqrp_in_t  beat,
  output dqrp_out_t      verdict
);

  localparam int POS_W = $clog2(MAX_PACKET + 1);
  localparam int LW    = (POS_W + 1 > 10) ? POS_W + 1 : 10;

  logic [POS_W-1:0] pos_r, pos_upd;
  logic [7:0]       hflags_r, hflags_upd;
  logic [15:0]      qcount_r, qcount_upd;
  dqrp_phase_t      phase_r, phase_upd;
  logic [5:0]       lrem_r, lrem_upd;
  logic [15:0]      qtype_r, qtype_upd;
  logic [15:0]      qclass_r, qclass_upd;
  logic [POS_W-1:0] qend_r, qend_upd;
  logic [1:0]       blk_r, blk_upd;
  logic             over_r, over_upd;

  logic [7:0]       b;
  logic [7:0]       lc;
  logic [POS_W-1:0] idx;
  logic [LW-1:0]    len;
  logic [LW-1:0]    ans_len;

  assign b   = beat.data_byte;
  assign lc  = to_lower(b);
  assign idx = pos_r - POS_W'(HEADER_BYTES);

  // state update for one beat
  always_comb begin
    pos_upd    = pos_r;
    hflags_upd = hflags_r;
    qcount_upd = qcount_r;
    phase_upd  = phase_r;
    lrem_upd   = lrem_r;
    qtype_upd  = qtype_r;
    qclass_upd = qclass_r;
    qend_upd   = qend_r;
    blk_upd    = blk_r;
    over_upd   = over_r;
    if (pos_r >= POS_W'(MAX_PACKET)) begin
      over_upd = 1'b1;
    end else begin
      pos_upd = pos_r + POS_W'(1);
      if (phase_r == PH_LEN || phase_r == PH_LABEL) begin
        if (idx >= POS_W'(NAME_WIRE)) begin
          blk_upd = 2'b00;
        end else begin
          if (lc != name_char(idx[4:0], 1'b0)) blk_upd[0] = 1'b0;
          if (lc != name_char(idx[4:0], 1'b1)) blk_upd[1] = 1'b0;
        end
      end
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_W'(2)) hflags_upd = b;
          if (pos_r == POS_W'(4)) qcount_upd = {b, 8'h00};
          if (pos_r == POS_W'(5)) qcount_upd = {qcount_r[15:8], b};
          if (pos_r == POS_W'(HEADER_BYTES - 1)) begin
            if ((hflags_r & FLAG_QR) != 8'h00) phase_upd = PH_BAD;
            else if ((hflags_r & OPCODE_MASK) != 8'h00 || qcount_r != 16'd1)
              phase_upd = PH_UNSUP;
            else phase_upd = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b == 8'h00) begin
            phase_upd = PH_TAIL;
            lrem_upd  = 6'd4;
          end else if ((b & PTR_MASK) != 8'h00 || b > 8'(LABEL_MAX)) begin
            phase_upd = PH_BAD;
          end else begin
            lrem_upd  = b[5:0];
            phase_upd = PH_LABEL;
          end
        end
        PH_LABEL: begin
          lrem_upd = lrem_r - 6'd1;
          if (lrem_upd == 6'd0) phase_upd = PH_LEN;
        end
        PH_TAIL: begin
          case (lrem_r)
            6'd4:    qtype_upd  = {b, 8'h00};
            6'd3:    qtype_upd  = {qtype_r[15:8], b};
            6'd2:    qclass_upd = {b, 8'h00};
            default: begin
              qclass_upd = {qclass_r[15:8], b};
              qend_upd   = pos_r + POS_W'(1);
              phase_upd  = PH_DONE;
            end
          endcase
          lrem_upd = lrem_r - 6'd1;
        end
        default: ;
      endcase
    end
  end

  assign ans_len = LW'(qend_upd) + LW'(ANSWER_BYTES);

  // verdict from the updated state
  always_comb begin
    verdict.drop            = 1'b0;
    verdict.flags_high      = FLAG_QR | {7'd0, hflags_upd[0]};
    verdict.response_code   = RCODE_NOERROR;
    verdict.answer_count    = 1'b0;
    len                     = '0;
    if (over_upd || phase_upd == PH_BAD || phase_upd == PH_HEADER ||
        phase_upd == PH_LEN || phase_upd == PH_LABEL || phase_upd == PH_TAIL) begin
      verdict.drop = 1'b1;
    end else if (phase_upd == PH_UNSUP) begin
      verdict.response_code = RCODE_NOTIMP;
      len = LW'(HEADER_BYTES);
    end else if (qclass_upd != 16'd1) begin
      verdict.response_code = RCODE_NOTIMP;
      len = LW'(qend_upd);
    end else if (blk_upd != 2'b00) begin
      verdict.response_code = RCODE_NXDOMAIN;
      len = LW'(qend_upd);
    end else if (qtype_upd != 16'd1) begin
      len = LW'(qend_upd);
    end else if (ans_len > LW'(MAX_PACKET)) begin
      verdict.drop = 1'b1;
    end else begin
      len = ans_len;
      verdict.answer_count = 1'b1;
    end
    if (verdict.drop) begin
      len                   = '0;
      verdict.flags_high    = 8'h00;
      verdict.response_code = RCODE_NOERROR;
      verdict.answer_count  = 1'b0;
    end
    verdict.response_length = (len > LW'(RESP_LEN_MAX)) ? 10'(RESP_LEN_MAX) : len[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && beat.last_byte)) begin
      pos_r    <= '0;
      hflags_r <= '0;
      qcount_r <= '0;
      phase_r  <= PH_HEADER;
      lrem_r   <= '0;
      qtype_r  <= '0;
      qclass_r <= '0;
      qend_r   <= '0;
      blk_r    <= 2'b11;
      over_r   <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_upd;
      hflags_r <= hflags_upd;
      qcount_r <= qcount_upd;
      phase_r  <= phase_upd;
      lrem_r   <= lrem_upd;
      qtype_r  <= qtype_upd;
      qclass_r <= qclass_upd;
      qend_r   <= qend_upd;
      blk_r    <= blk_upd;
      over_r   <= over_upd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dns_query_responder_parser.sv
// ---------------------------------------------------------------------------
// DNS query responder parser
// Byte-stream DNS query checker giving one verdict per packet.
// ---------------------------------------------------------------------------
// Takes one query byte per beat and sustains one beat per cycle unless a final
// beat is held back by a stalled verdict. Each beat is registered, then the parser
// state is updated from it as it leaves that register; the beat marked last also
// loads the verdict into the output register. Non-final beats keep flowing while a
// verdict waits; only a final beat waits for the output register to empty.
`default_nettype none

module dns_query_responder_parser
  import dqrp_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dqrp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dqrp_out_t      out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  dqrp_in_t  s1_beat_r;
  logic      out_valid_r, out_valid_nxt;
  dqrp_out_t out_data_r;
  dqrp_out_t verdict;
  logic      s1_go;
  logic      in_take;

  assign s1_go    = s1_valid_r && (!s1_beat_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_beat_r.last_byte) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  dqrp_parser #(
    .MAX_PACKET (MAX_PACKET)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .beat    (s1_beat_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_beat_r <= in_data;
    if (s1_go && s1_beat_r.last_byte) out_data_r <= verdict;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/dqrp_checker.sv
// ---------------------------------------------------------------------------
// DNS query parser checker
// Port-level assertions on the verdict channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dns_query_responder_parser_macros.svh"

module dqrp_port_props
  import dqrp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire dqrp_out_t out_data
);

  `DQRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled verdict changed")

  `DQRP_ASSERT_SAME(a_drop_clean, out_valid && out_data.drop, out_data.response_length == 10'd0 && out_data.flags_high == 8'h00 && out_data.response_code == RCODE_NOERROR && !out_data.answer_count, "drop verdict carries fields")

  `DQRP_ASSERT_SAME(a_flags_form, out_valid && !out_data.drop, out_data.flags_high[7] && out_data.flags_high[6:1] == 6'd0, "bad response flags")

  `DQRP_ASSERT_SAME(a_rcode_set, out_valid, out_data.response_code == RCODE_NOERROR || out_data.response_code == RCODE_NXDOMAIN || out_data.response_code == RCODE_NOTIMP, "unknown response code")

  `DQRP_ASSERT_SAME(a_answer_len, out_valid && out_data.answer_count, out_data.response_code == RCODE_NOERROR && out_data.response_length > 10'(HEADER_BYTES + ANSWER_BYTES), "answer without room")

endmodule

bind dns_query_responder_parser dqrp_port_props u_dqrp_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: bench/dqrp_checker.sv
// ---------------------------------------------------------------------------
// DNS query parser checker
// Watches the byte channel and the verdict channel, runs its own parse of
// each query to predict the verdict, and compares every verdict beat field
// by field with the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module dqrp_checker
  import dqrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire dqrp_in_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire dqrp_out_t out_data,
  output int             mismatches,
  output int             verdicts_open,
  output int             verdicts_seen,
  output int             drops_seen,
  output int             answers_seen
);

  localparam logic [8*NAME_WIRE-1:0] HOST_ORG = {8'd5, "local", 8'd7,
    8'h61, 8'h64, 8'h67, 8'h75, 8'h61, 8'h72, 8'h64, 8'd3, "org", 8'd0};
  localparam logic [8*NAME_WIRE-1:0] HOST_COM = {8'd5, "local", 8'd7,
    8'h61, 8'h64, 8'h67, 8'h75, 8'h61, 8'h72, 8'h64, 8'd3, "com", 8'd0};

  int          rx_count;
  logic [7:0]  hdr_flags;
  logic [15:0] qd_count;
  dqrp_phase_t phase;
  logic [5:0]  label_left;
  logic [15:0] qtype;
  logic [15:0] qclass;
  int          qend;
  logic [1:0]  host_hits;
  bit          oversized;

  dqrp_out_t verdict_q[$];
  int err_n  = 0;
  int seen_n = 0;
  int drop_n = 0;
  int ans_n  = 0;

  task automatic clear_parse();
    rx_count   = 0;
    hdr_flags  = '0;
    qd_count   = '0;
    phase      = PH_HEADER;
    label_left = '0;
    qtype      = '0;
    qclass     = '0;
    qend       = 0;
    host_hits  = 2'b11;
    oversized  = 1'b0;
  endtask

  task automatic match_host(input logic [7:0] b);
    int         idx;
    logic [7:0] c;
    idx = rx_count - HEADER_BYTES;
    c = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    if (idx >= NAME_WIRE) begin
      host_hits = 2'b00;
    end else begin
      if (c != HOST_ORG[8*(NAME_WIRE-1-idx) +: 8]) host_hits[0] = 1'b0;
      if (c != HOST_COM[8*(NAME_WIRE-1-idx) +: 8]) host_hits[1] = 1'b0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (phase)
      PH_HEADER: begin
        if (rx_count == 2) hdr_flags = b;
        if (rx_count == 4) qd_count[15:8] = b;
        if (rx_count == 5) qd_count[7:0] = b;
        if (rx_count == HEADER_BYTES - 1) begin
          if ((hdr_flags & FLAG_QR) != 0) phase = PH_BAD;
          else if ((hdr_flags & OPCODE_MASK) != 0 || qd_count != 16'd1) phase = PH_UNSUP;
          else phase = PH_LEN;
        end
      end
      PH_LEN: begin
        match_host(b);
        if (b == 8'd0) begin
          phase = PH_TAIL;
          label_left = 6'd4;
        end else if ((b & PTR_MASK) != 0 || b > LABEL_MAX) begin
          phase = PH_BAD;
        end else begin
          label_left = b[5:0];
          phase = PH_LABEL;
        end
      end
      PH_LABEL: begin
        match_host(b);
        label_left = label_left - 6'd1;
        if (label_left == 6'd0) phase = PH_LEN;
      end
      PH_TAIL: begin
        case (label_left)
          6'd4: qtype[15:8] = b;
          6'd3: qtype[7:0] = b;
          6'd2: qclass[15:8] = b;
          default: begin
            qclass[7:0] = b;
            qend = rx_count + 1;
            phase = PH_DONE;
          end
        endcase
        label_left = label_left - 6'd1;
      end
      default: ;
    endcase
  endtask

  task automatic absorb_beat(input dqrp_in_t beat);
    dqrp_out_t v;
    int        len;
    if (rx_count >= MAX_PACKET_DEF) begin
      oversized = 1'b1;
    end else begin
      parse_byte(beat.data_byte);
      rx_count++;
    end
    if (beat.last_byte) begin
      v = '0;
      len = 0;
      if (oversized || (phase != PH_DONE && phase != PH_UNSUP)) begin
        v.drop = 1'b1;
      end else if (phase == PH_UNSUP) begin
        v.response_code = RCODE_NOTIMP;
        len = HEADER_BYTES;
      end else if (qclass != 16'd1) begin
        v.response_code = RCODE_NOTIMP;
        len = qend;
      end else if (host_hits != 2'b00) begin
        v.response_code = RCODE_NXDOMAIN;
        len = qend;
      end else if (qtype != 16'd1) begin
        v.response_code = RCODE_NOERROR;
        len = qend;
      end else if (qend + ANSWER_BYTES > MAX_PACKET_DEF) begin
        v.drop = 1'b1;
      end else begin
        v.response_code = RCODE_NOERROR;
        v.answer_count = 1'b1;
        len = qend + ANSWER_BYTES;
      end
      if (!v.drop) begin
        v.flags_high = FLAG_QR | {7'd0, hdr_flags[0]};
        v.response_length = (len > RESP_LEN_MAX) ? 10'(RESP_LEN_MAX) : 10'(len);
      end
      verdict_q.push_back(v);
      clear_parse();
    end
  endtask

  task automatic check_verdict(input dqrp_out_t got);
    dqrp_out_t want;
    if (verdict_q.size() == 0) begin
      $error("verdict beat %h with no packet pending", got);
      err_n++;
    end else begin
      want = verdict_q.pop_front();
      seen_n++;
      if (got.drop) drop_n++;
      if (got.answer_count) ans_n++;
      if (got.drop !== want.drop) begin
        $error("drop: expected %0d, got %0d", want.drop, got.drop);
        err_n++;
      end
      if (got.response_length !== want.response_length) begin
        $error("response_length: expected %0d, got %0d",
               want.response_length, got.response_length);
        err_n++;
      end
      if (got.flags_high !== want.flags_high) begin
        $error("flags_high: expected %02h, got %02h", want.flags_high, got.flags_high);
        err_n++;
      end
      if (got.response_code !== want.response_code) begin
        $error("response_code: expected %0d, got %0d",
               want.response_code, got.response_code);
        err_n++;
      end
      if (got.answer_count !== want.answer_count) begin
        $error("answer_count: expected %0d, got %0d", want.answer_count, got.answer_count);
        err_n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      verdict_q.delete();
    end else begin
      if (in_valid && !in_stall) absorb_beat(in_data);
      if (out_valid && !out_stall) check_verdict(out_data);
    end
    mismatches    <= err_n;
    verdicts_open <= verdict_q.size();
    verdicts_seen <= seen_n;
    drops_seen    <= drop_n;
    answers_seen  <= ans_n;
  end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// DNS query parser testbench
// Feeds directed and random query packets one byte per beat with random
// gaps and verdict-side stalls; the checker predicts and compares verdicts.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import dqrp_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  localparam logic [7:0]  FLAG_RD       = 8'h01;
  localparam logic [7:0]  OPCODE_STATUS = 8'h10;
  localparam logic [15:0] QTYPE_A       = 16'd1;
  localparam logic [15:0] QTYPE_AAAA    = 16'd28;
  localparam logic [15:0] QCLASS_IN     = 16'd1;
  localparam logic [15:0] QCLASS_CH     = 16'd3;

  localparam logic [8*15-1:0] BLOCKED_STEM = {8'd5, "local", 8'd7,
    8'h61, 8'h64, 8'h67, 8'h75, 8'h61, 8'h72, 8'h64, 8'd3};

  typedef enum int {NM_RANDOM, NM_ORG, NM_COM, NM_NEAR} host_kind_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  dqrp_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  dqrp_out_t out_data;

  int fail_count, due, seen, drops, answers;
  int idle_cycles  = 0;
  int stall_left   = 0;
  int beats_sent   = 0;
  int packets_sent = 0;
  bit calm         = 1'b0;
  logic [7:0] pkt[$];

  dns_query_responder_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  dqrp_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatches    (fail_count),
    .verdicts_open (due),
    .verdicts_seen (seen),
    .drops_seen    (drops),
    .answers_seen  (answers)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      calm <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(40, 300)) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : stall_gen
    int hold;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold = pick_gap();
      out_stall <= (hold > 0);
      stall_left <= (hold > 0) ? hold - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] label_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      c = 8'h61 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c - 8'd32;
    end else if (r < 7) begin
      c = 8'h30 + 8'($urandom_range(0, 9));
    end else begin
      c = rand_byte();
    end
    return c;
  endfunction

  task automatic put_header(input logic [7:0] f2, input logic [15:0] qd);
    pkt.push_back(rand_byte());
    pkt.push_back(rand_byte());
    pkt.push_back(f2);
    pkt.push_back(rand_byte());
    pkt.push_back(qd[15:8]);
    pkt.push_back(qd[7:0]);
    repeat (6) pkt.push_back(rand_byte());
  endtask

  task automatic put_label(input int len);
    logic [7:0] lb;
    lb = 8'(len);
    pkt.push_back(lb);
    repeat (len) pkt.push_back(label_char());
  endtask

  task automatic put_random_name();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) put_label(($urandom_range(0, 19) == 0) ? LABEL_MAX : $urandom_range(1, 12));
    pkt.push_back(8'h00);
  endtask

  // labels filling exactly total bytes, terminator included
  task automatic put_sized_name(input int total);
    int rem, chunk;
    rem = total - 1;
    while (rem > 0) begin
      chunk = (rem > LABEL_MAX + 1) ? LABEL_MAX + 1 : rem;
      if (rem - chunk == 1) chunk = LABEL_MAX;
      put_label(chunk - 1);
      rem -= chunk;
    end
    pkt.push_back(8'h00);
  endtask

  task automatic put_blocked(input bit dot_com);
    logic [8*18-1:0] host;
    logic [7:0]      c;
    host = {BLOCKED_STEM, dot_com ? "com" : "org"};
    for (int i = 0; i < 18; i++) begin
      c = host[8*(17-i) +: 8];
      if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1)) c = c - 8'd32;
      pkt.push_back(c);
    end
    pkt.push_back(8'h00);
  endtask

  // blocked name with one letter changed or an extra label appended
  task automatic put_near_blocked();
    int pos;
    put_blocked(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) begin
      pos = pkt.size() - 19 + ($urandom_range(0, 1) ? $urandom_range(1, 5)
                                                    : $urandom_range(15, 17));
      pkt[pos] = pkt[pos] ^ 8'h01;
    end else begin
      void'(pkt.pop_back());
      put_label($urandom_range(1, 3));
      pkt.push_back(8'h00);
    end
  endtask

  task automatic put_tail(input logic [15:0] qt, input logic [15:0] qc);
    pkt.push_back(qt[15:8]);
    pkt.push_back(qt[7:0]);
    pkt.push_back(qc[15:8]);
    pkt.push_back(qc[7:0]);
  endtask

  task automatic build_query(input logic [7:0] f2, input logic [15:0] qd,
                             input host_kind_t kind, input logic [15:0] qt,
                             input logic [15:0] qc);
    put_header(f2, qd);
    case (kind)
      NM_RANDOM: put_random_name();
      NM_ORG:    put_blocked(1'b0);
      NM_COM:    put_blocked(1'b1);
      default:   put_near_blocked();
    endcase
    put_tail(qt, qc);
  endtask

  task automatic drive_beat(input logic [7:0] b, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) drive_beat(pkt[i], i == pkt.size() - 1);
    packets_sent++;
    pkt.delete();
  endtask

  initial begin
    int         r, cut;
    host_kind_t kind;
    logic [7:0] f2;
    logic [15:0] qd, qt, qc;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    build_query(FLAG_RD, 16'd1, NM_RANDOM, QTYPE_A, QCLASS_IN);
    send_packet();
    build_query(8'h00, 16'd1, NM_ORG, QTYPE_A, QCLASS_IN);
    send_packet();
    build_query(8'h07, 16'd1, NM_COM, QTYPE_AAAA, QCLASS_IN);
    send_packet();
    build_query(FLAG_RD, 16'd1, NM_ORG, QTYPE_A, QCLASS_CH);
    send_packet();
    build_query(8'h00, 16'd1, NM_RANDOM, QTYPE_AAAA, QCLASS_IN);
    send_packet();
    build_query(FLAG_QR | FLAG_RD, 16'd1, NM_RANDOM, QTYPE_A, QCLASS_IN);
    send_packet();
    build_query(OPCODE_STATUS | FLAG_RD, 16'd1, NM_RANDOM, QTYPE_A, QCLASS_IN);
    send_packet();
    put_header(FLAG_RD, 16'd0);
    send_packet();
    build_query(8'h00, 16'h0100, NM_RANDOM, QTYPE_A, QCLASS_IN);
    send_packet();
    put_header(8'h00, 16'd1);
    send_packet();
    repeat (5) pkt.push_back(rand_byte());
    send_packet();
    pkt.push_back(8'hff);
    send_packet();
    put_header(8'h00, 16'd1);
    pkt.push_back(PTR_MASK);
    pkt.push_back(8'h0c);
    put_tail(QTYPE_A, QCLASS_IN);
    send_packet();
    put_header(8'h00, 16'd1);
    pkt.push_back(8'h40);
    pkt.push_back(rand_byte());
    send_packet();
    put_header(8'h00, 16'd1);
    put_random_name();
    send_packet();
    put_header(8'h00, 16'd1);
    put_random_name();
    repeat (3) pkt.push_back(8'h00);
    send_packet();
    put_header(8'hff & ~FLAG_QR & ~OPCODE_MASK, 16'd1);
    pkt.push_back(8'd63);
    repeat (63) pkt.push_back(8'hff);
    pkt.push_back(8'd1);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_tail(QTYPE_A, QCLASS_IN);
    send_packet();
    build_query(8'h00, 16'd1, NM_NEAR, QTYPE_A, QCLASS_IN);
    repeat (6) pkt.push_back(rand_byte());
    send_packet();
    // answer would just fit, but the packet runs one byte past the limit
    put_header(FLAG_RD, 16'd1);
    put_sized_name(MAX_PACKET_DEF - ANSWER_BYTES - HEADER_BYTES - 4);
    put_tail(QTYPE_A, QCLASS_IN);
    while (pkt.size() < MAX_PACKET_DEF + 1) pkt.push_back(rand_byte());
    send_packet();

    // random
    while (beats_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      f2 = rand_byte() & 8'h07;
      qd = 16'd1;
      qt = ($urandom_range(0, 9) < 7) ? QTYPE_A
         : ($urandom_range(0, 1) ? QTYPE_AAAA : 16'($urandom_range(0, 65535)));
      qc = ($urandom_range(0, 19) < 17) ? QCLASS_IN : 16'($urandom_range(0, 65535));
      cut = $urandom_range(0, 99);
      kind = (cut < 60) ? NM_RANDOM : (cut < 75) ? NM_ORG : (cut < 87) ? NM_COM : NM_NEAR;
      if (r < 55) begin
        build_query(f2, qd, kind, qt, qc);
        if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 8)) pkt.push_back(rand_byte());
      end else if (r < 65) begin
        case ($urandom_range(0, 2))
          0:       f2 = rand_byte() | FLAG_QR;
          1:       f2 = {1'b0, 4'($urandom_range(1, 15)), f2[2:0]};
          default: qd = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
        endcase
        build_query(f2, qd, kind, qt, qc);
      end else if (r < 80) begin
        build_query(f2, qd, kind, qt, qc);
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (r < 90) begin
        put_header(f2, qd);
        if ($urandom_range(0, 1)) put_label($urandom_range(1, 8));
        pkt.push_back($urandom_range(0, 1) ? (PTR_MASK | 8'($urandom_range(0, 63)))
                                           : 8'($urandom_range(LABEL_MAX + 1, 191)));
        repeat ($urandom_range(0, 6)) pkt.push_back(rand_byte());
      end else begin
        repeat ($urandom_range(1, 40)) pkt.push_back(rand_byte());
      end
      send_packet();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d packets in %0d query bytes with gaps and stalls on both channels",
             packets_sent, beats_sent);
    $display("Checked %0d verdicts: %0d dropped, %0d with an answer record",
             seen, drops, answers);
    if (fail_count == 0 && due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
